// ===== design/vsfl_pkg.sv =====
package vsfl_pkg;

	localparam int MAX_OBJECTS = 1024;
	localparam int SLOT_W      = $clog2(MAX_OBJECTS);
	localparam int CNT_W       = SLOT_W + 1;
	localparam int POINTS_W    = 7;
	localparam int STRIDE_W    = 8;
	localparam int INDEX_W     = 18;
	localparam int STATUS_W    = 2;
	localparam int POINTS_MIN  = 1;
	localparam int POINTS_MAX  = 64;
	localparam int MULT_ONE    = 1;
	localparam int MULT_THREE  = 3;

	// two quotient bits per cycle
	localparam int DIV_CYCLES  = INDEX_W / 2;
	localparam int DIV_CNT_W   = $clog2(DIV_CYCLES);

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef struct packed {
		logic capture;
		logic rd;
		logic mul;
		logic step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic op_free;
		logic out_open;
	} sts_t;

	function automatic logic [STRIDE_W-1:0] stride_of(input logic [POINTS_W-1:0] p);
		logic [POINTS_W-1:0] c;
		logic [STRIDE_W-1:0] w;
		c = p;
		if (p < POINTS_W'(POINTS_MIN))
			c = POINTS_W'(POINTS_MIN);
		if (p > POINTS_W'(POINTS_MAX))
			c = POINTS_W'(POINTS_MAX);
		w = {1'b0, c};
		if (c == 7'd1 || c == 7'd2 || c == 7'd4)
			return STRIDE_W'(w * STRIDE_W'(MULT_ONE));
		return STRIDE_W'(w * STRIDE_W'(MULT_THREE));
	endfunction

endpackage

// ===== design/vsfl_ctrl.sv =====
module vsfl_ctrl
	import vsfl_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_MUL,
		S_DIV,
		S_FIN
	} state_t;

	state_t               state_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			div_cnt_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						div_cnt_q <= '0;
						state_q   <= S_RD;
					end
				end
				S_RD: begin
					// allocate reads the top of stack, free runs the divider
					if (sts.op_free)
						state_q <= S_DIV;
					else
						state_q <= S_MUL;
				end
				S_MUL: state_q <= S_FIN;
				S_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == DIV_CNT_W'(DIV_CYCLES - 2))
						state_q <= S_FIN;
				end
				S_FIN: begin
					if (sts.out_open)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		in_ready    = (state_q == S_IDLE);
		cmd.capture = (state_q == S_IDLE) && in_valid;
		cmd.rd      = (state_q == S_RD);
		cmd.mul     = (state_q == S_MUL);
		// first divide step shares the read cycle
		cmd.step    = ((state_q == S_RD) && sts.op_free) || (state_q == S_DIV);
		cmd.finish  = (state_q == S_FIN) && sts.out_open;
	end

endmodule

// ===== design/vsfl_dp.sv =====
module vsfl_dp
	import vsfl_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output sts_t                sts,
	input  logic                in_op,
	input  logic [INDEX_W-1:0]  in_index,
	input  logic                cfg_we,
	input  logic [POINTS_W-1:0] cfg_data,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [INDEX_W-1:0]  out_base,
	output logic [STATUS_W-1:0] out_status,
	output logic [CNT_W-1:0]    out_free
);

	logic [SLOT_W-1:0]   mem [MAX_OBJECTS];
	logic [POINTS_W-1:0] points_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    min_q;     // lowest count reached; entries below never rewritten
	logic                op_q;
	logic [INDEX_W-1:0]  quo_q;
	logic [STRIDE_W-1:0] rem_q;
	logic [SLOT_W-1:0]   rd_data_q;
	logic [SLOT_W-1:0]   rd_idx_q;
	logic                rd_fresh_q;
	logic [INDEX_W-1:0]  prod_q;
	logic                out_valid_q;
	logic [INDEX_W-1:0]  out_base_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [CNT_W-1:0]    out_free_q;

	logic [STRIDE_W-1:0] stride;
	logic [CNT_W-1:0]    top;
	logic [SLOT_W-1:0]   slot;
	logic [STRIDE_W:0]   t1, t2;
	logic [STRIDE_W-1:0] r1, r2;
	logic                b1, b2;
	logic                empty, full, range_err;

	assign stride = stride_of(points_q);
	assign top    = cnt_q - 1'b1;
	assign slot   = rd_fresh_q ? rd_idx_q : rd_data_q;

	// two restoring divide steps
	always_comb begin
		t1 = {rem_q, quo_q[INDEX_W-1]};
		b1 = (t1 >= {1'b0, stride});
		r1 = b1 ? STRIDE_W'(t1 - {1'b0, stride}) : STRIDE_W'(t1);
		t2 = {r1, quo_q[INDEX_W-2]};
		b2 = (t2 >= {1'b0, stride});
		r2 = b2 ? STRIDE_W'(t2 - {1'b0, stride}) : STRIDE_W'(t2);
	end

	assign empty     = (cnt_q == '0);
	assign full      = (cnt_q >= CNT_W'(MAX_OBJECTS));
	assign range_err = (quo_q >= INDEX_W'(MAX_OBJECTS));

	assign sts.op_free  = op_q;
	assign sts.out_open = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.finish && op_q && !full && !range_err)
			mem[cnt_q[SLOT_W-1:0]] <= quo_q[SLOT_W-1:0];
		if (cmd.rd)
			rd_data_q <= mem[top[SLOT_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= in_op;
			quo_q <= in_index;
			rem_q <= '0;
		end else if (cmd.step) begin
			quo_q <= {quo_q[INDEX_W-3:0], b1, b2};
			rem_q <= r2;
		end
		if (cmd.rd) begin
			rd_idx_q   <= top[SLOT_W-1:0];
			rd_fresh_q <= (top < min_q);
		end
		if (cmd.mul)
			prod_q <= INDEX_W'(slot * stride);
		if (cmd.finish) begin
			out_base_q   <= '0;
			out_status_q <= ST_OK;
			out_free_q   <= cnt_q;
			if (op_q == OP_ALLOC) begin
				if (empty) begin
					out_status_q <= ST_EMPTY;
				end else begin
					out_base_q <= prod_q;
					out_free_q <= top;
				end
			end else if (full) begin
				out_status_q <= ST_FULL;
			end else if (range_err) begin
				out_status_q <= ST_RANGE;
			end else begin
				out_free_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			points_q    <= POINTS_W'(POINTS_MIN);
			cnt_q       <= CNT_W'(MAX_OBJECTS);
			min_q       <= CNT_W'(MAX_OBJECTS);
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				points_q <= cfg_data;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
				if (op_q == OP_ALLOC) begin
					if (!empty) begin
						cnt_q <= top;
						if (top < min_q)
							min_q <= top;
					end
				end else if (!full && !range_err) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_base   = out_base_q;
	assign out_status = out_status_q;
	assign out_free   = out_free_q;

endmodule

// ===== design/vertex_slot_free_list_allocator_unit.sv =====
// Allocate reads the top of stack, multiplies the slot by the stride, then finishes;
// free runs the radix-4 divider (two quotient bits a cycle), then finishes.
// Throughput: one item at a time.
// A result waits in the output register while the next item is accepted.
// Reset (arst_n, async low): all 1024 slots free, stride 1, no item in flight;
// the stack contents need no clearing pass.
module vertex_slot_free_list_allocator_unit
	import vsfl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_data,     // points_per_object
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,      // [17:0] vertex_index
	input  logic        s_tuser,      // operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,      // [17:0] base_index, [28:18] free_slots
	output logic [1:0]  m_tuser       // status
);

	cmd_t                cmd;
	sts_t                sts;
	logic [INDEX_W-1:0]  base;
	logic [CNT_W-1:0]    free_cnt;

	vsfl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	vsfl_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_op      (s_tuser),
		.in_index   (s_tdata[INDEX_W-1:0]),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_base   (base),
		.out_status (m_tuser),
		.out_free   (free_cnt)
	);

	assign m_tdata = {3'b000, free_cnt, base};

endmodule

// ===== design/vsfl_checker.sv =====
module vsfl_checker
	import vsfl_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [1:0]  m_tuser
);

	// one item in flight: no accept in the cycle after an accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted on consecutive cycles");

	a_base_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != ST_OK) |-> (m_tdata[17:0] == '0))
		else $error("nonzero base on failed operation");

	a_free_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[28:18] <= 11'(MAX_OBJECTS)))
		else $error("free count beyond slot total");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == ST_EMPTY) |-> (m_tdata[28:18] == '0))
		else $error("empty status with free slots");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("output item dropped or changed while stalled");

endmodule

bind vertex_slot_free_list_allocator_unit vsfl_checker u_vsfl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ===== tb/vsfl_alloc_checker.sv =====
`timescale 1ns / 100ps

module vsfl_alloc_checker
	import vsfl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_data,     // points_per_object
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,      // [17:0] vertex_index
	input  logic        s_tuser,      // operation
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,      // [17:0] base_index, [28:18] free_slots
	input  logic [1:0]  m_tuser,      // status
	output int          fail_count,
	output int          pending,
	output int unsigned cur_stride
);

	typedef struct packed {
		logic [INDEX_W-1:0] base;
		status_t            status;
		logic [CNT_W-1:0]   free;
	} slot_result_t;

	localparam int MAX_REPORTS = 10;

	logic [SLOT_W-1:0] free_slot_stack [MAX_OBJECTS];
	logic [CNT_W-1:0]  slots_left;
	slot_result_t      expected_results [$];

	// zero counts as one, anything above 64 as 64
	function automatic int unsigned pitch_of(input logic [POINTS_W-1:0] pts);
		int unsigned p;
		p = pts;
		if (p < POINTS_MIN)
			p = POINTS_MIN;
		if (p > POINTS_MAX)
			p = POINTS_MAX;
		if (p == 1 || p == 2 || p == 4)
			return p * MULT_ONE;
		return p * MULT_THREE;
	endfunction

	function automatic slot_result_t apply_request(input op_t op,
			input logic [INDEX_W-1:0] vidx);
		slot_result_t r;
		int unsigned  quo;
		r.base   = '0;
		r.status = ST_OK;
		if (op == OP_ALLOC) begin
			if (slots_left == 0) begin
				r.status = ST_EMPTY;
			end else begin
				slots_left = slots_left - 1'b1;
				r.base = INDEX_W'(free_slot_stack[slots_left[SLOT_W-1:0]] * cur_stride);
			end
		end else begin
			quo = vidx / cur_stride;
			// full stack wins over a bad slot
			if (slots_left >= CNT_W'(MAX_OBJECTS)) begin
				r.status = ST_FULL;
			end else if (quo >= MAX_OBJECTS) begin
				r.status = ST_RANGE;
			end else begin
				free_slot_stack[slots_left[SLOT_W-1:0]] = SLOT_W'(quo);
				slots_left = slots_left + 1'b1;
			end
		end
		r.free = slots_left;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		slot_result_t want;
		slot_result_t got;
		if (!arst_n) begin
			for (int i = 0; i < MAX_OBJECTS; i++)
				free_slot_stack[i] = SLOT_W'(i);
			slots_left = CNT_W'(MAX_OBJECTS);
			cur_stride = pitch_of(POINTS_W'(POINTS_MIN));
			expected_results.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_we)
				cur_stride = pitch_of(cfg_data);
			// results trail their items, so pop before push
			if (m_tvalid && m_tready) begin
				got.base   = m_tdata[INDEX_W-1:0];
				got.free   = m_tdata[INDEX_W +: CNT_W];
				got.status = status_t'(m_tuser);
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("%0t: result with no item pending: base %0d status %0d free %0d",
							$realtime, got.base, got.status, got.free);
				end else begin
					want = expected_results.pop_front();
					if (got.base !== want.base || got.status !== want.status ||
							got.free !== want.free) begin
						fail_count++;
						if (fail_count <= MAX_REPORTS)
							$display("%0t: mismatch: expected base %0d status %0d free %0d,",
								$realtime, want.base, want.status, want.free,
								" got base %0d status %0d free %0d",
								got.base, got.status, got.free);
					end
				end
			end
			if (s_tvalid && s_tready)
				expected_results.insert(expected_results.size(),
					apply_request(op_t'(s_tuser), s_tdata[INDEX_W-1:0]));
			pending = expected_results.size();
		end
	end

endmodule

// ===== tb/tb_vertex_slot_free_list_allocator_unit.sv =====
`timescale 1ns / 100ps

module tb_vertex_slot_free_list_allocator_unit;
	import vsfl_pkg::*;

	localparam int INDEX_MAX      = 196607;
	localparam int LONG_HOLD      = 300;
	localparam int WATCHDOG_LIMIT = 3000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we;
	logic [6:0]  cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;

	int          fail_count;
	int          pending;
	int unsigned cur_stride;
	int          quiet_cycles;
	bit          idle_on = 1'b1;
	bit          long_hold_req = 1'b0;

	vertex_slot_free_list_allocator_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	vsfl_alloc_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.fail_count (fail_count),
		.pending    (pending),
		.cur_stride (cur_stride)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic offer_item(input op_t op, input logic [INDEX_W-1:0] vidx);
		int g;
		g = pick_gap();
		if (g != 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= 24'(vidx);
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	task automatic wait_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_points(input logic [6:0] pts);
		wait_results();
		cfg_we   <= 1'b1;
		cfg_data <= pts;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_phase(input logic [6:0] pts, input int n, input int alloc_pct,
			input bit hold_out);
		op_t op;
		int  pick;
		int  edge_idx;
		logic [INDEX_W-1:0] vidx;
		write_points(pts);
		long_hold_req = hold_out;
		for (int i = 0; i < n; i++) begin
			op = ($urandom_range(0, 99) < alloc_pct) ? OP_ALLOC : OP_FREE;
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				// a slot base, possibly off the boundary
				vidx = INDEX_W'($urandom_range(0, MAX_OBJECTS - 1) * cur_stride +
					$urandom_range(0, cur_stride - 1));
			end else if (pick < 90) begin
				vidx = INDEX_W'($urandom_range(0, INDEX_MAX));
			end else if (pick < 95) begin
				vidx = pick[0] ? INDEX_W'(INDEX_MAX) : '0;
			end else begin
				// first index past the last slot
				edge_idx = MAX_OBJECTS * cur_stride;
				vidx = (edge_idx > INDEX_MAX) ? INDEX_W'(INDEX_MAX) : INDEX_W'(edge_idx);
			end
			offer_item(op, vidx);
		end
	endtask

	// receiver: random ready, plus one long hold-off on request
	initial begin
		int g;
		m_tready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			g = pick_gap();
			if (g != 0) begin
				m_tready <= 1'b0;
				repeat (g) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		cfg_we   <= 1'b0;
		cfg_data <= '0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= OP_ALLOC;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// stride 1 after reset, stack full
		offer_item(OP_FREE, '0);
		offer_item(OP_FREE, INDEX_W'(INDEX_MAX));
		offer_item(OP_ALLOC, INDEX_W'(INDEX_MAX));
		offer_item(OP_FREE, INDEX_W'(INDEX_MAX));
		offer_item(OP_FREE, INDEX_W'(MAX_OBJECTS));
		offer_item(OP_FREE, INDEX_W'(MAX_OBJECTS - 1));
		offer_item(OP_ALLOC, '0);

		// zero points behaves as one
		write_points(7'd0);
		offer_item(OP_ALLOC, '1);
		offer_item(OP_FREE, INDEX_W'(MAX_OBJECTS - 2));

		// stride 9: off-boundary free, double free
		write_points(7'd3);
		offer_item(OP_ALLOC, '0);
		offer_item(OP_FREE, INDEX_W'(9 * 1022 + 8));
		offer_item(OP_ALLOC, '0);
		offer_item(OP_ALLOC, '0);
		offer_item(OP_FREE, INDEX_W'(9 * 1000));
		offer_item(OP_FREE, INDEX_W'(9 * 1000));
		offer_item(OP_ALLOC, '0);

		// points above range clamp to 64, stride 192
		write_points(7'd127);
		offer_item(OP_ALLOC, '0);
		offer_item(OP_ALLOC, '0);
		offer_item(OP_FREE, INDEX_W'(INDEX_MAX));
		offer_item(OP_FREE, '0);
		offer_item(OP_ALLOC, '0);

		run_phase(7'd2, 100, 50, 1'b0);
		run_phase(7'd4, 100, 60, 1'b1);
		run_phase(7'd3, 100, 40, 1'b0);
		idle_on = 1'b0;
		run_phase(7'd5, 100, 55, 1'b0);
		idle_on = 1'b1;
		run_phase(7'd64, 100, 50, 1'b0);
		run_phase(7'd127, 100, 45, 1'b0);
		run_phase(7'd0, 100, 50, 1'b0);
		run_phase(7'($urandom_range(0, 127)), 100, 60, 1'b0);

		// refill past full; at stride 192 every index is in range
		run_phase(7'd127, 50, 0, 1'b0);

		run_phase(7'd63, 30, 50, 1'b0);

		wait_results();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
design/vsfl_pkg.sv
design/vsfl_ctrl.sv
design/vsfl_dp.sv
design/vertex_slot_free_list_allocator_unit.sv
design/vsfl_checker.sv
tb/vsfl_alloc_checker.sv
tb/tb_vertex_slot_free_list_allocator_unit.sv
